>>> rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch seconds converter
// Holds the controller states, the command and status groups passed
// between controller and datapath, and the calendar constants.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  // Field widths of the input and result words.
  localparam int EPOCH_W  = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Whole days since the base date fit in 16 bits (at most 49710).
  localparam int DAYS_W = 16;

  // Time-of-day divisors.
  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int HOURS_PER_DAY = 24;

  // Reciprocals for dividing any 32-bit value by 60 and by 24, with the
  // right shift that gives the quotient from the 64-bit product.
  localparam int               PROD_W   = 64;
  localparam logic [EPOCH_W-1:0] RECIP_60 = 32'h8888_8889;
  localparam int               SHIFT_60 = 37;
  localparam logic [EPOCH_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam int               SHIFT_24 = 36;

  // Calendar constants.
  localparam int BASE_YEAR      = 1970;
  localparam int DAYS_LEAP_YEAR = 366;
  localparam int DAYS_COMMON    = 365;
  localparam int DAYS_LEAP_FEB  = 29;
  localparam int MONTH_FEB      = 2;
  localparam int MONTH_DEC      = 12;

  // Year counters modulo 100 and 400 for the leap rule.
  localparam int CENTURY   = 100;
  localparam int QUAD_CENT = 400;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_END,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic start;
    logic div_mul;
    logic div_end;
    logic year_sub;
    logic month_sub;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic phase_last;
    logic year_more;
    logic month_more;
  } sts_t;

  // Length of a month, February taking a day more in leap years.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'(DAYS_LEAP_FEB) : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/esc_dp.sv
// ----------------------------------------------------------------------------
// esc_dp: datapath of the epoch seconds converter
// Reciprocal multiplication splits off seconds, minutes and hours;
// a subtractor then strips whole years and whole months from the days.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_dp
  import esc_pkg::*;
(
  input  wire logic                clk,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic [EPOCH_W-1:0]  in_epoch_seconds,
  output logic      [YEAR_W-1:0]   out_year_out,
  output logic      [MONTH_W-1:0]  out_month_out,
  output logic      [DAY_W-1:0]    out_day_out,
  output logic      [HOUR_W-1:0]   out_hour_out,
  output logic      [MINUTE_W-1:0] out_minute_out,
  output logic      [SECOND_W-1:0] out_second_out
);

  // Working registers.
  logic [EPOCH_W-1:0]  rem_r;
  logic [PROD_W-1:0]   prod_r;
  logic [1:0]          phase_r;
  logic [SECOND_W-1:0] sec_r;
  logic [MINUTE_W-1:0] min_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [DAYS_W-1:0]   days_r;
  logic [YEAR_W-1:0]   year_r;
  logic [6:0]          y100_r;
  logic [8:0]          y400_r;
  logic [MONTH_W-1:0]  month_r;

  logic [5:0]          divisor;
  logic [EPOCH_W-1:0]  recip;
  logic [EPOCH_W-1:0]  quot;
  logic [5:0]          part;
  logic                leap;
  logic [8:0]          year_len;
  logic [DAY_W-1:0]    month_len;

  // The hour division uses 24, the other two use 60.
  assign divisor = (phase_r == 2'd2) ? 6'(HOURS_PER_DAY) :
                   (phase_r == 2'd1) ? 6'(MINS_PER_HOUR) : 6'(SECS_PER_MIN);
  assign recip   = (phase_r == 2'd2) ? RECIP_24 : RECIP_60;

  // Quotient from the registered product; the remainder is below 64, so
  // only the low six bits of the subtraction are needed.
  assign quot = (phase_r == 2'd2) ? EPOCH_W'(prod_r >> SHIFT_24) :
                                    EPOCH_W'(prod_r >> SHIFT_60);
  assign part = rem_r[5:0] - 6'(quot[5:0] * divisor);

  // Full Gregorian leap rule from the year counters.
  assign leap      = (y400_r == 9'd0) || ((y100_r != 7'd0) && (year_r[1:0] == 2'b00));
  assign year_len  = leap ? 9'(DAYS_LEAP_YEAR) : 9'(DAYS_COMMON);
  assign month_len = month_days(month_r, leap);

  // Status to the controller.
  always_comb begin
    sts.phase_last = (phase_r == 2'd2);
    sts.year_more  = days_r >= DAYS_W'(year_len);
    sts.month_more = (month_r != 4'(MONTH_DEC)) && (days_r >= DAYS_W'(month_len));
  end

  // Divisions, year and month stepping.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r   <= in_epoch_seconds;
      phase_r <= 2'd0;
    end
    if (cmd.div_mul) begin
      prod_r <= PROD_W'(rem_r) * PROD_W'(recip);
    end
    if (cmd.div_end) begin
      phase_r <= phase_r + 2'd1;
      rem_r   <= quot;
      case (phase_r)
        2'd0: begin
          sec_r <= part;
        end
        2'd1: begin
          min_r <= part;
        end
        default: begin
          hour_r  <= part[HOUR_W-1:0];
          days_r  <= quot[DAYS_W-1:0];
          year_r  <= 12'(BASE_YEAR);
          y100_r  <= 7'(BASE_YEAR % CENTURY);
          y400_r  <= 9'(BASE_YEAR % QUAD_CENT);
          month_r <= 4'd1;
        end
      endcase
    end
    if (cmd.year_sub) begin
      days_r <= days_r - DAYS_W'(year_len);
      year_r <= year_r + 12'd1;
      y100_r <= (y100_r == 7'(CENTURY - 1)) ? 7'd0 : y100_r + 7'd1;
      y400_r <= (y400_r == 9'(QUAD_CENT - 1)) ? 9'd0 : y400_r + 9'd1;
    end
    if (cmd.month_sub) begin
      days_r  <= days_r - DAYS_W'(month_len);
      month_r <= month_r + 4'd1;
    end
  end

  // Output word register, separate from the working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_year_out   <= year_r;
      out_month_out  <= month_r;
      out_day_out    <= days_r[DAY_W-1:0] + 5'd1;
      out_hour_out   <= hour_r;
      out_minute_out <= min_r;
      out_second_out <= sec_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl: controller of the epoch seconds converter
// Sequences the three divisions, the year and month loops and the hand-off
// of the finished word to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ctrl
  import esc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_DIV;
      ST_DIV:     state_nxt = ST_DIV_END;
      ST_DIV_END: state_nxt = sts.phase_last ? ST_YEAR : ST_DIV;
      ST_YEAR:    if (!sts.year_more) state_nxt = ST_MONTH;
      ST_MONTH:   if (!sts.month_more) state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:    cmd.start     = in_valid;
      ST_DIV:     cmd.div_mul   = 1'b1;
      ST_DIV_END: cmd.div_end   = 1'b1;
      ST_YEAR:    cmd.year_sub  = sts.year_more;
      ST_MONTH:   cmd.month_sub = sts.month_more;
      ST_FINISH:  cmd.load_out  = out_free;
      default:    cmd = '0;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to Gregorian date and time
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year,
// month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// One word is converted at a time. The second, minute and hour splits are
// done by reciprocal multiplication, each in a multiply state and a closing
// state. Whole years after 1970 are then stripped one at a time, then whole
// months before the result month, and the finished word is loaded into the
// output register. The input stays stalled until the result is loaded, and
// the next word can be taken in the cycle after. A result held by a stalled
// receiver delays the load of the following result, and with it the next
// input word.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [EPOCH_W-1:0]  in_epoch_seconds,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [YEAR_W-1:0]   out_year_out,
  output logic      [MONTH_W-1:0]  out_month_out,
  output logic      [DAY_W-1:0]    out_day_out,
  output logic      [HOUR_W-1:0]   out_hour_out,
  output logic      [MINUTE_W-1:0] out_minute_out,
  output logic      [SECOND_W-1:0] out_second_out
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic.
  esc_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_epoch_seconds (in_epoch_seconds),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_hour_out     (out_hour_out),
    .out_minute_out   (out_minute_out),
    .out_second_out   (out_second_out)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the epoch seconds to calendar converter
// Drives second counts into the converter and checks each converted date
// against a date worked out in the testbench. Covers directed boundary
// dates, random counts, back-to-back traffic and output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import esc_pkg::*;

  // Converted date, one field for each result port.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } cal_date_t;

  // Expected date together with the count it came from.
  typedef struct packed {
    logic [EPOCH_W-1:0] secs;
    cal_date_t          date;
  } date_expect_t;

  localparam int SECS_PER_DAY  = SECS_PER_MIN * MINS_PER_HOUR * HOURS_PER_DAY;
  localparam int LAST_DAY      = 49710;
  localparam int IDLE_PERCENT  = 38;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 300;
  localparam int MAX_PRINTED   = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [EPOCH_W-1:0]  in_epoch_seconds = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [YEAR_W-1:0]   out_year_out;
  logic [MONTH_W-1:0]  out_month_out;
  logic [DAY_W-1:0]    out_day_out;
  logic [HOUR_W-1:0]   out_hour_out;
  logic [MINUTE_W-1:0] out_minute_out;
  logic [SECOND_W-1:0] out_second_out;

  // Common month lengths, February taking its leap day separately.
  int month_len_tbl [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  date_expect_t pending_dates [$];
  int           mismatch_count = 0;
  logic         quiet = 1'b0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  epoch_seconds_to_calendar u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_hour_out     (out_hour_out),
    .out_minute_out   (out_minute_out),
    .out_second_out   (out_second_out)
  );

  always #5 clk = ~clk;

  // Gregorian leap rule over the full century exceptions.
  function automatic logic is_leap(input int unsigned yr);
    if (yr % QUAD_CENT == 0) return 1'b1;
    if (yr % CENTURY == 0) return 1'b0;
    return (yr % 4) == 0;
  endfunction

  // Works out the calendar date and time of day for a second count.
  function automatic cal_date_t calendar_of(input logic [EPOCH_W-1:0] secs);
    cal_date_t   r;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    logic        lp;
    t        = secs;
    r.second = SECOND_W'(t % SECS_PER_MIN);
    t        = t / SECS_PER_MIN;
    r.minute = MINUTE_W'(t % MINS_PER_HOUR);
    t        = t / MINS_PER_HOUR;
    r.hour   = HOUR_W'(t % HOURS_PER_DAY);
    days     = t / HOURS_PER_DAY;
    // Strip whole years from 1970 onwards.
    yr = BASE_YEAR;
    lp = is_leap(yr);
    len = lp ? DAYS_LEAP_YEAR : DAYS_COMMON;
    while (days >= len) begin
      days = days - len;
      yr   = yr + 1;
      lp   = is_leap(yr);
      len  = lp ? DAYS_LEAP_YEAR : DAYS_COMMON;
    end
    // Strip whole months; December takes whatever is left.
    mo = 1;
    len = month_len_tbl[0];
    while (mo < MONTH_DEC && days >= len) begin
      days = days - len;
      mo   = mo + 1;
      len  = (mo == MONTH_FEB && lp) ? DAYS_LEAP_FEB : month_len_tbl[mo-1];
    end
    r.year  = YEAR_W'(yr);
    r.month = MONTH_W'(mo);
    r.day   = DAY_W'(days + 1);
    return r;
  endfunction

  // Prints one line for a mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input logic [EPOCH_W-1:0] secs,
                                 input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("ERROR %0t: %s for seconds 0x%08h: got %0d, want %0d",
               $realtime, what, secs, got, want);
  endtask

  // Offers one word, idling first at random, and records its expected date.
  task automatic send_word(input logic [EPOCH_W-1:0] secs);
    date_expect_t e;
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    e.secs = secs;
    e.date = calendar_of(secs);
    pending_dates.push_back(e);
  endtask

  // Stops offering and waits until every expected date has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Receiver: a requested long hold-off first, else random stalls.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Each accepted result word is compared with the oldest expected date.
  always @(posedge clk) begin
    date_expect_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result word", '0, out_year_out, 0);
      end else begin
        e = pending_dates.pop_front();
        if (out_year_out !== e.date.year)
          report_mismatch("year", e.secs, out_year_out, e.date.year);
        if (out_month_out !== e.date.month)
          report_mismatch("month", e.secs, out_month_out, e.date.month);
        if (out_day_out !== e.date.day)
          report_mismatch("day", e.secs, out_day_out, e.date.day);
        if (out_hour_out !== e.date.hour)
          report_mismatch("hour", e.secs, out_hour_out, e.date.hour);
        if (out_minute_out !== e.date.minute)
          report_mismatch("minute", e.secs, out_minute_out, e.date.minute);
        if (out_second_out !== e.date.second)
          report_mismatch("second", e.secs, out_second_out, e.date.second);
      end
    end
  end

  // Field extremes, day and year edges, and the leap centuries.
  task automatic test_directed();
    logic [EPOCH_W-1:0] edges [$];
    edges = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
              32'd31535999, 32'd31536000,       // end of 1970, start of 1971
              32'd68169600, 32'd68256000,       // 29 February 1972, 1 March 1972
              32'd946684799, 32'd946684800,     // turn of the year 2000
              32'd951782400, 32'd951868800,     // leap day in 2000, day after
              32'd4107542399, 32'd4107542400,   // 2100 has no leap day
              32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (edges[i]) send_word(edges[i]);
    wait_for_results();
  endtask

  // Random counts: uniform, day edges, the early months of random years, and small counts.
  task automatic test_random(input int count);
    longint      secs;
    int unsigned pick;
    int unsigned yr_pick;
    int unsigned start_day;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        secs = $urandom;
      end else if (pick < 70) begin
        secs = longint'($urandom_range(LAST_DAY)) * SECS_PER_DAY;
        if ($urandom_range(1)) secs = secs + SECS_PER_DAY - 1;
      end else if (pick < 90) begin
        yr_pick   = $urandom_range(2106, BASE_YEAR);
        start_day = 0;
        for (int unsigned y = BASE_YEAR; y < yr_pick; y++)
          start_day += is_leap(y) ? DAYS_LEAP_YEAR : DAYS_COMMON;
        secs = longint'(start_day + $urandom_range(65)) * SECS_PER_DAY;
        case ($urandom_range(2))
          0: secs = secs + SECS_PER_DAY - 1;
          1: secs = secs + $urandom_range(SECS_PER_DAY - 1);
          default: ;
        endcase
      end else begin
        secs = $urandom_range(100000000);
      end
      if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;
      send_word(EPOCH_W'(secs));
    end
    wait_for_results();
  endtask

  // A long stretch with no idling on either side.
  task automatic test_back_to_back(input int count);
    quiet <= 1'b1;
    for (int n = 0; n < count; n++) send_word($urandom);
    wait_for_results();
    quiet <= 1'b0;
  endtask

  // Receiver holds off for a long stretch while words keep being offered.
  task automatic test_output_hold(input int count);
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < count; n++) send_word($urandom);
    wait_for_results();
  endtask

  // Sender pauses until every date is out, then carries on.
  task automatic test_drain_pause();
    for (int n = 0; n < 5; n++) send_word($urandom);
    wait_for_results();
    for (int n = 0; n < 5; n++) send_word($urandom_range(100000));
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_back_to_back(60);
    test_output_hold(10);
    test_drain_pause();
    test_random(340);
    // Let any stray word show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
